// ===== rtl/core/urbq_pkg.sv =====
// Shared types and constants for the serial-port ring buffer queues.
// Used by urbq_ram, urbq_ctrl and uart_ring_buffer_queues.
package urbq_pkg;

  localparam int DEF_RX_DEPTH = 64;
  localparam int DEF_TX_DEPTH = 64;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 3;
  localparam int LEVEL_W      = 7;

  localparam logic [BYTE_W-1:0] EMPTY_READ_BYTE = 8'hFF;

  // Event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE = 3'd0,
    CMD_TX_DONE = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_FLUSH   = 3'd4
  } cmd_t;

  // Decisions taken when an event is accepted, finished once memory data returns
  typedef struct packed {
    logic               tx_mem;      // next queued byte goes to the line
    logic               tx_direct;   // sent byte goes straight to the line
    logic [BYTE_W-1:0]  direct_byte;
    logic               rd_mem;      // host read returns stored byte
    logic               rd_empty;    // host read on empty ring
    logic               acc;         // host send taken
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_space;
  } step_t;

endpackage

// ===== rtl/core/urbq_ram.sv =====
// Single-write, single-read byte memory with a registered read port.
// Depends on urbq_pkg for the data width.
module urbq_ram
  import urbq_pkg::*;
#(
  parameter int DEPTH = DEF_RX_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [BYTE_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [BYTE_W-1:0]        rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/urbq_ctrl.sv =====
// Pointer and fill-count control for the receive and transmit rings.
// Drives the memory ports and the per-event decision; depends on urbq_pkg.
module urbq_ctrl
  import urbq_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [CMD_W-1:0]            cmd,
  input  logic [BYTE_W-1:0]           data_in,
  output step_t                       step,
  output logic                        rx_we,
  output logic [$clog2(RX_DEPTH)-1:0] rx_waddr,
  output logic                        rx_re,
  output logic [$clog2(RX_DEPTH)-1:0] rx_raddr,
  output logic                        tx_we,
  output logic [$clog2(TX_DEPTH)-1:0] tx_waddr,
  output logic                        tx_re,
  output logic [$clog2(TX_DEPTH)-1:0] tx_raddr,
  output logic [BYTE_W-1:0]           wdata
);

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int RFW = $clog2(RX_DEPTH + 1);
  localparam int TFW = $clog2(TX_DEPTH + 1);

  logic [RPW-1:0] rx_write_ptr, rx_write_ptr_next;
  logic [RPW-1:0] rx_read_ptr, rx_read_ptr_next;
  logic [RFW-1:0] rx_fill, rx_fill_next;
  logic [TPW-1:0] tx_write_ptr, tx_write_ptr_next;
  logic [TPW-1:0] tx_read_ptr, tx_read_ptr_next;
  logic [TFW-1:0] tx_fill, tx_fill_next;
  logic [31:0]    rx_level_w;
  logic [31:0]    tx_space_w;

  function automatic logic [RPW-1:0] rx_wrap(input logic [RPW-1:0] p);
    return (p == RPW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TPW-1:0] tx_wrap(input logic [TPW-1:0] p);
    return (p == TPW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Event decode: next pointers, counts, memory requests
  always_comb begin
    rx_write_ptr_next = rx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    rx_fill_next      = rx_fill;
    tx_write_ptr_next = tx_write_ptr;
    tx_read_ptr_next  = tx_read_ptr;
    tx_fill_next      = tx_fill;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    step              = '0;
    step.direct_byte  = data_in;
    if (accept) begin
      unique case (cmd)
        CMD_RX_BYTE: begin
          if (rx_fill < RFW'(RX_DEPTH)) begin
            rx_we             = 1'b1;
            rx_fill_next      = rx_fill + 1'b1;
            rx_write_ptr_next = rx_wrap(rx_write_ptr);
          end
        end
        CMD_TX_DONE: begin
          if (tx_fill >= TFW'(2)) begin
            tx_re            = 1'b1;
            step.tx_mem      = 1'b1;
            tx_read_ptr_next = tx_wrap(tx_read_ptr);
            tx_fill_next     = tx_fill - 1'b1;
          end else if (tx_fill == TFW'(1)) begin
            tx_fill_next = '0;
          end
        end
        CMD_SEND: begin
          if (tx_fill == '0) begin
            step.tx_direct = 1'b1;
            step.acc       = 1'b1;
            tx_fill_next   = TFW'(1);
          end else if (tx_fill < TFW'(TX_DEPTH)) begin
            tx_we             = 1'b1;
            step.acc          = 1'b1;
            tx_fill_next      = tx_fill + 1'b1;
            tx_write_ptr_next = tx_wrap(tx_write_ptr);
          end
        end
        CMD_READ: begin
          if (rx_fill == '0) begin
            step.rd_empty = 1'b1;
          end else begin
            rx_re            = 1'b1;
            step.rd_mem      = 1'b1;
            rx_fill_next     = rx_fill - 1'b1;
            rx_read_ptr_next = rx_wrap(rx_read_ptr);
          end
        end
        CMD_FLUSH: begin
          rx_read_ptr_next = rx_write_ptr;
          rx_fill_next     = '0;
        end
        default: begin
        end
      endcase
    end
    rx_level_w    = 32'(rx_fill_next);
    tx_space_w    = 32'(TX_DEPTH) - 32'(tx_fill_next);
    step.rx_level = rx_level_w[LEVEL_W-1:0];
    step.tx_space = tx_space_w[LEVEL_W-1:0];
  end

  assign rx_waddr = rx_write_ptr;
  assign rx_raddr = rx_read_ptr;
  assign tx_waddr = tx_write_ptr;
  assign tx_raddr = tx_read_ptr;
  assign wdata    = data_in;

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_write_ptr <= '0;
      rx_read_ptr  <= '0;
      rx_fill      <= '0;
      tx_write_ptr <= '0;
      tx_read_ptr  <= '0;
      tx_fill      <= '0;
    end else begin
      rx_write_ptr <= rx_write_ptr_next;
      rx_read_ptr  <= rx_read_ptr_next;
      rx_fill      <= rx_fill_next;
      tx_write_ptr <= tx_write_ptr_next;
      tx_read_ptr  <= tx_read_ptr_next;
      tx_fill      <= tx_fill_next;
    end
  end

endmodule

// ===== rtl/core/uart_ring_buffer_queues.sv =====
// Top level of the serial-port receive/transmit ring buffer queues.
// Instantiates urbq_ctrl and two urbq_ram; depends on urbq_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: cmd and
//   data_in. Output channel (out_valid / out_stall) returns one result beat
//   per event, in order: line byte handoff, host read data, send status,
//   receive level and transmit free space.
//   Path: the ring memory read and the stage register load when an event
//   is accepted; the output register loads from that stage while the
//   output is not stalled, and the result beat is then presented.
//   Throughput: one event per cycle sustained while the output is drained;
//   the single stage between the memory read and the output register sets
//   this figure.
//   When the receiver stalls, the output register holds its beat, the stage
//   behind it holds, and in_stall rises once that stage is occupied.
//   Reset clears pointers, fill counts and all valid flags; ring memory
//   contents are not cleared and need no clearing pass.
module uart_ring_buffer_queues
  import urbq_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [BYTE_W-1:0]  data_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               line_tx_valid,
  output logic [BYTE_W-1:0]  line_tx_byte,
  output logic [BYTE_W-1:0]  read_data,
  output logic               send_accepted,
  output logic [LEVEL_W-1:0] rx_level,
  output logic [LEVEL_W-1:0] tx_space
);

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);

  logic              accept;
  logic              s1_valid;
  logic              s1_adv;
  step_t             step;
  step_t             s1_step;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [RPW-1:0]    rx_waddr, rx_raddr;
  logic [TPW-1:0]    tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  // Handshake
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  urbq_ctrl #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .data_in  (data_in),
    .step     (step),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .wdata    (wdata)
  );

  urbq_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  urbq_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage payload: decision waits beside the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= step;
    end
  end

  // Output register: merge memory data with the decision
  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      line_tx_valid <= s1_step.tx_mem || s1_step.tx_direct;
      line_tx_byte  <= s1_step.tx_mem    ? tx_rdata :
                       s1_step.tx_direct ? s1_step.direct_byte : '0;
      read_data     <= s1_step.rd_mem   ? rx_rdata :
                       s1_step.rd_empty ? EMPTY_READ_BYTE : '0;
      send_accepted <= s1_step.acc;
      rx_level      <= s1_step.rx_level;
      tx_space      <= s1_step.tx_space;
    end
  end

`ifndef SYNTHESIS
  // Input is only held off when the middle stage is occupied
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without an occupied stage");

  // A blocked stage keeps its beat
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("stage beat lost while output stalled");

  // A read result excludes any transmit activity
  a_read_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != '0) |-> !line_tx_valid && !send_accepted)
    else $error("read result mixed with transmit result");

  // Line byte is zero unless handed off
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_tx_valid |-> line_tx_byte == '0)
    else $error("line byte set without handoff");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for uart_ring_buffer_queues: directed events, then random episodes.
// Depends on urbq_pkg and the RTL under rtl/core; a built-in model predicts result beats of untyped rows.
`timescale 1ns / 100ps

module tb;
  import urbq_pkg::*;

  localparam int RX_RING         = DEF_RX_DEPTH;
  localparam int TX_RING         = DEF_TX_DEPTH;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRESSURE_AT     = 400;
  localparam int PRESSURE_CYCLES = 300;

  // Codes the block decodes to no operation
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef enum int {EP_RX_FILL, EP_RX_DRAIN, EP_TX_FILL, EP_TX_DRAIN, EP_MIXED} episode_t;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic [BYTE_W-1:0]  rd;
    logic               acc;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] space;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] payload;
    logic              typed;
    result_t           want;
  } event_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd = CMD_READ;
  logic [BYTE_W-1:0]  data_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               line_tx_valid;
  logic [BYTE_W-1:0]  line_tx_byte;
  logic [BYTE_W-1:0]  read_data;
  logic               send_accepted;
  logic [LEVEL_W-1:0] rx_level;
  logic [LEVEL_W-1:0] tx_space;

  uart_ring_buffer_queues uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .data_in       (data_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_tx_valid (line_tx_valid),
    .line_tx_byte  (line_tx_byte),
    .read_data     (read_data),
    .send_accepted (send_accepted),
    .rx_level      (rx_level),
    .tx_space      (tx_space)
  );

  always #5 clk = ~clk;

  // Shadow copy of both rings
  logic [BYTE_W-1:0] rx_ring [RX_RING];
  logic [BYTE_W-1:0] tx_ring [TX_RING];
  int rx_wr = 0, rx_rd = 0, rx_fill = 0;
  int tx_wr = 0, tx_rd = 0, tx_fill = 0;

  // Coverage tallies
  int rx_dropped = 0, tx_refused = 0, empty_reads = 0, rx_peak = 0, tx_peak = 0;

  event_row_t offered_q [$];
  result_t    expected_q [$];
  event_row_t plan_q [$];
  int errors = 0;
  int items_in = 0;
  int beats_out = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  // Advance the shadow rings by one event and return the result beat it produces
  function automatic result_t ring_event(input logic [CMD_W-1:0] op,
                                         input logic [BYTE_W-1:0] d);
    result_t r;
    r = '0;
    case (op)
      CMD_RX_BYTE: begin
        if (rx_fill < RX_RING) begin
          rx_ring[rx_wr] = d;
          rx_fill++;
          rx_wr = (rx_wr == RX_RING - 1) ? 0 : rx_wr + 1;
        end else begin
          rx_dropped++;
        end
      end
      CMD_TX_DONE: begin
        if (tx_fill >= 2) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_ring[tx_rd];
          tx_rd = (tx_rd == TX_RING - 1) ? 0 : tx_rd + 1;
          tx_fill--;
        end else if (tx_fill == 1) begin
          tx_fill = 0;
        end
      end
      CMD_SEND: begin
        if (tx_fill == 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = d;
          r.acc      = 1'b1;
          tx_fill    = 1;
        end else if (tx_fill < TX_RING) begin
          tx_ring[tx_wr] = d;
          tx_fill++;
          tx_wr = (tx_wr == TX_RING - 1) ? 0 : tx_wr + 1;
          r.acc = 1'b1;
        end else begin
          tx_refused++;
        end
      end
      CMD_READ: begin
        if (rx_fill == 0) begin
          r.rd = EMPTY_READ_BYTE;
          empty_reads++;
        end else begin
          r.rd = rx_ring[rx_rd];
          rx_fill--;
          rx_rd = (rx_rd == RX_RING - 1) ? 0 : rx_rd + 1;
        end
      end
      CMD_FLUSH: begin
        rx_rd   = rx_wr;
        rx_fill = 0;
      end
      default: ;
    endcase
    if (rx_fill > rx_peak) rx_peak = rx_fill;
    if (tx_fill > tx_peak) tx_peak = tx_fill;
    r.level = LEVEL_W'(rx_fill);
    r.space = LEVEL_W'(TX_RING - tx_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // One directed row; typed rows carry the result read straight off the spec
  task automatic plan_event(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] d,
                            input bit typed, input bit tv, input int tbyte, input int rd,
                            input bit acc, input int level, input int space);
    event_row_t row;
    row.op      = op;
    row.payload = d;
    row.typed   = typed;
    row.want    = '{tv, BYTE_W'(tbyte), BYTE_W'(rd), acc, LEVEL_W'(level), LEVEL_W'(space)};
    plan_q.push_back(row);
  endtask

  // Sender: bursts of back-to-back beats separated by random gaps
  task automatic offer_beat(input event_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    offered_q.push_back(row);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= row.op;
    data_in  <= row.payload;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Input beats feed the predictor; output beats are checked in order
  always @(posedge clk) begin : monitor
    event_row_t row;
    result_t    pred;
    result_t    want;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        row  = offered_q.pop_front();
        pred = ring_event(row.op, row.payload);
        expected_q.push_back(row.typed ? row.want : pred);
        items_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        beats_out++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat, rx_level", rx_level, 0);
        end else begin
          want = expected_q.pop_front();
          if (line_tx_valid !== want.tx_valid)
            report_mismatch("line_tx_valid", line_tx_valid, want.tx_valid);
          if (line_tx_byte !== want.tx_byte)
            report_mismatch("line_tx_byte", line_tx_byte, want.tx_byte);
          if (read_data !== want.rd)
            report_mismatch("read_data", read_data, want.rd);
          if (send_accepted !== want.acc)
            report_mismatch("send_accepted", send_accepted, want.acc);
          if (rx_level !== want.level)
            report_mismatch("rx_level", rx_level, want.level);
          if (tx_space !== want.space)
            report_mismatch("tx_space", tx_space, want.space);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Receiver stall pattern, plus one long hold-off to back the block up
  int  stall_mode = 0, mode_left = 0, hold_left = 0, stall_phase = 0;
  bit  pressure_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!pressure_done && items_in >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      stall_phase = (stall_phase + 1) % 8;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase < 5);
      endcase
    end
  end

  // Watchdog on cycles with no beat moving either way
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
    $display("[uart_ring_buffer_queues] ERROR");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    event_row_t row;
    episode_t   ep;
    int         ep_left;
    int         n;
    logic [CMD_W-1:0] op;
    ep_left = 0;
    n       = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed table: empty-ring cases, spare codes, flush, send paths
    plan_event(CMD_READ,    8'h00, 1, 0, 8'h00, 8'hFF, 0, 0, 64);
    plan_event(CMD_TX_DONE, 8'hFF, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_FLUSH,   8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_SPARE_5, 8'hFF, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_SPARE_6, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_SPARE_7, 8'hAA, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_RX_BYTE, 8'h00, 1, 0, 8'h00, 8'h00, 0, 1, 64);
    plan_event(CMD_RX_BYTE, 8'hFF, 1, 0, 8'h00, 8'h00, 0, 2, 64);
    plan_event(CMD_READ,    8'h55, 1, 0, 8'h00, 8'h00, 0, 1, 64);
    plan_event(CMD_READ,    8'h00, 1, 0, 8'h00, 8'hFF, 0, 0, 64);
    plan_event(CMD_READ,    8'h00, 1, 0, 8'h00, 8'hFF, 0, 0, 64);
    plan_event(CMD_SEND,    8'hA5, 1, 1, 8'hA5, 8'h00, 1, 0, 63);
    plan_event(CMD_SEND,    8'h5A, 1, 0, 8'h00, 8'h00, 1, 0, 62);
    plan_event(CMD_SEND,    8'hFF, 1, 0, 8'h00, 8'h00, 1, 0, 61);
    plan_event(CMD_TX_DONE, 8'h00, 1, 1, 8'h5A, 8'h00, 0, 0, 62);
    plan_event(CMD_TX_DONE, 8'h00, 1, 1, 8'hFF, 8'h00, 0, 0, 63);
    plan_event(CMD_TX_DONE, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_TX_DONE, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_RX_BYTE, 8'h3C, 0, 0, 0, 0, 0, 0, 0);
    plan_event(CMD_RX_BYTE, 8'hC3, 0, 0, 0, 0, 0, 0, 0);
    plan_event(CMD_FLUSH,   8'hFF, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    plan_event(CMD_READ,    8'h00, 1, 0, 8'h00, 8'hFF, 0, 0, 64);
    plan_event(CMD_SEND,    8'h00, 1, 1, 8'h00, 8'h00, 1, 0, 63);
    plan_event(CMD_SPARE_7, 8'hFF, 1, 0, 8'h00, 8'h00, 0, 0, 63);
    plan_event(CMD_TX_DONE, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 64);
    foreach (plan_q[i]) offer_beat(plan_q[i]);

    // Random episodes: most lean on one operation so the rings hit full and empty; mixed ones draw any code
    while (n < RANDOM_ITEMS) begin
      if (ep_left == 0) begin
        ep      = episode_t'($urandom_range(EP_RX_FILL, EP_MIXED));
        ep_left = $urandom_range(20, 90);
      end
      ep_left--;
      if (ep != EP_MIXED && $urandom_range(0, 99) < 80) begin
        case (ep)
          EP_RX_FILL:  op = CMD_RX_BYTE;
          EP_RX_DRAIN: op = CMD_READ;
          EP_TX_FILL:  op = CMD_SEND;
          default:     op = CMD_TX_DONE;
        endcase
      end else begin
        op = CMD_W'($urandom_range(0, CMD_SPARE_7));
      end
      row         = '0;
      row.op      = op;
      row.payload = BYTE_W'($urandom);
      offer_beat(row);
      n++;
    end

    // Let everything drain, then watch for stray beats
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d events, %0d result beats; rx peak %0d, tx peak %0d",
             items_in, beats_out, rx_peak, tx_peak);
    $display("%0d rx bytes dropped full, %0d sends refused, %0d empty reads",
             rx_dropped, tx_refused, empty_reads);
    if (errors == 0) begin
      $display("[uart_ring_buffer_queues] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[uart_ring_buffer_queues] ERROR");
    end
    $finish;
  end

endmodule
